// File: rtl/lpbc_pkg.sv
package lpbc_pkg;

    // Layer numbering: backgrounds 0..3, then sprite, then backdrop
    localparam int NUM_BG     = 4;
    localparam int NUM_LAYERS = NUM_BG + 1;
    localparam int LAYER_W    = 3;
    localparam int CHAN_W     = 5;
    localparam int NUM_CHAN   = 3;

    typedef logic [LAYER_W-1:0] t_layer;
    typedef logic [15:0]        t_pixel;
    typedef logic [14:0]        t_color;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [4:0]         t_key;
    typedef logic [4:0]         t_weight;
    typedef logic [5:0]         t_mask;

    localparam t_layer LAYER_SPRITE   = 3'd4;
    localparam t_layer LAYER_BACKDROP = 3'd5;
    localparam t_key   KEY_NONE       = 5'd31;
    localparam t_key   KEY_STEP       = 5'd5;
    localparam t_chan  CHAN_MAX       = 5'd31;
    localparam t_weight WEIGHT_MAX    = 5'd16;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BLEND_MODE    = 3'd0,
        CFG_FIRST_MASK    = 3'd1,
        CFG_SECOND_MASK   = 3'd2,
        CFG_ALPHA_FIRST   = 3'd3,
        CFG_ALPHA_SECOND  = 3'd4,
        CFG_FADE_AMOUNT   = 3'd5,
        CFG_BG_PRIORITIES = 3'd6,
        CFG_BACKDROP      = 3'd7
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_ALPHA  = 2'd1,
        MODE_BRIGHT = 2'd2,
        MODE_DARK   = 2'd3
    } t_mode;

    // Operation chosen by the front end for the back end
    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_ALPHA  = 2'd1,
        OP_BRIGHT = 2'd2,
        OP_DARK   = 2'd3
    } t_op;

    typedef struct packed {
        t_mode       blend_mode;
        t_mask       first_mask;
        t_mask       second_mask;
        t_weight     alpha_first;
        t_weight     alpha_second;
        t_weight     fade_amount;
        logic [7:0]  bg_priorities;
        t_color      backdrop_color;
    } t_cfg;

    typedef struct packed {
        t_op    op;
        t_color top_color;
        t_color second_color;
    } t_item;

    // Queue between front and back end (depth 2 or more)
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    function automatic t_weight sat16(input t_weight w);
        return (w > WEIGHT_MAX) ? WEIGHT_MAX : w;
    endfunction

    function automatic logic [7:0] expand5(input t_chan c);
        return {c, c[4:2]};
    endfunction

endpackage

// File: rtl/lpbc_if.sv
interface lpbc_in_if;
    import lpbc_pkg::*;

    logic   valid;
    logic   ready;
    t_pixel bg0_pixel;
    t_pixel bg1_pixel;
    t_pixel bg2_pixel;
    t_pixel bg3_pixel;
    t_pixel sprite_pixel;
    logic [1:0] sprite_priority;
    logic   sprite_semi;

    modport source (
        output valid, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel,
               sprite_pixel, sprite_priority, sprite_semi,
        input  ready
    );
    modport sink (
        input  valid, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel,
               sprite_pixel, sprite_priority, sprite_semi,
        output ready
    );
endinterface

interface lpbc_out_if;
    import lpbc_pkg::*;

    logic        valid;
    logic        ready;
    t_color      final_color;
    logic [31:0] rgba_pixel;

    modport source (output valid, final_color, rgba_pixel, input ready);
    modport sink (input valid, final_color, rgba_pixel, output ready);
endinterface

interface lpbc_cfg_if;
    import lpbc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// File: rtl/layer_priority_blend_compositor.sv
// Layer compositor: one pixel transaction in, one composited pixel out, at
// one pixel per clock sustained while the output is not stalled. The front
// end ranks the four backgrounds, the sprite and the backdrop and picks the
// effect in the accept cycle; a two-entry queue decouples it from the back
// end, which does the per channel blend, brighten or darken and loads the
// output register. A result passes through the queue entry and then the
// output register; input ready drops only once the queue is full behind a
// stalled output. Configuration writes are always accepted and should be
// issued while no pixel is in flight.
module layer_priority_blend_compositor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpbc_in_if.sink    i_in,
    lpbc_cfg_if.sink   i_cfg,
    lpbc_out_if.source o_out
);
    import lpbc_pkg::*;

    t_cfg  r_cfg;
    t_item front_item, queue_head;
    logic  push, pop, queue_full, queue_empty;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_addr'(i_cfg.addr))
                CFG_BLEND_MODE:    r_cfg.blend_mode     <= t_mode'(i_cfg.data[1:0]);
                CFG_FIRST_MASK:    r_cfg.first_mask     <= i_cfg.data[5:0];
                CFG_SECOND_MASK:   r_cfg.second_mask    <= i_cfg.data[5:0];
                CFG_ALPHA_FIRST:   r_cfg.alpha_first    <= i_cfg.data[4:0];
                CFG_ALPHA_SECOND:  r_cfg.alpha_second   <= i_cfg.data[4:0];
                CFG_FADE_AMOUNT:   r_cfg.fade_amount    <= i_cfg.data[4:0];
                CFG_BG_PRIORITIES: r_cfg.bg_priorities  <= i_cfg.data[7:0];
                CFG_BACKDROP:      r_cfg.backdrop_color <= i_cfg.data[14:0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    lpbc_front u_front (
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    lpbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (queue_head)
    );

    lpbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item        (queue_head),
        .i_queue_empty (queue_empty),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

// File: rtl/lpbc_front.sv
module lpbc_front (
    lpbc_in_if.sink         i_in,
    input  lpbc_pkg::t_cfg  i_cfg,
    input  logic            i_queue_full,
    output logic            o_push,
    output lpbc_pkg::t_item o_item
);
    import lpbc_pkg::*;

    t_pixel px   [NUM_LAYERS];
    t_key   lkey [NUM_LAYERS];
    logic   lsemi[NUM_LAYERS];

    t_key   k1, k2;
    t_layer id1, id2;
    t_color c1, c2;
    logic   semi1;
    logic   top_first, second_ok;

    // Accept a transaction whenever the queue has room
    assign i_in.ready = !i_queue_full;
    assign o_push     = i_in.valid && !i_queue_full;

    // Gather layers and their ranking keys
    always_comb begin
        px[0] = i_in.bg0_pixel;
        px[1] = i_in.bg1_pixel;
        px[2] = i_in.bg2_pixel;
        px[3] = i_in.bg3_pixel;
        px[NUM_BG] = i_in.sprite_pixel;
        for (int n = 0; n < NUM_BG; n++) begin
            lkey[n]  = t_key'(i_cfg.bg_priorities[2*n +: 2]) * KEY_STEP + t_key'(n + 1);
            lsemi[n] = 1'b0;
        end
        lkey[NUM_BG]  = t_key'(i_in.sprite_priority) * KEY_STEP;
        lsemi[NUM_BG] = i_in.sprite_semi;
    end

    // Keep the two lowest keys, earlier layer wins a tie
    always_comb begin
        k1    = KEY_NONE;
        k2    = KEY_NONE;
        id1   = LAYER_BACKDROP;
        id2   = LAYER_BACKDROP;
        c1    = i_cfg.backdrop_color;
        c2    = i_cfg.backdrop_color;
        semi1 = 1'b0;
        for (int i = 0; i < NUM_LAYERS; i++) begin
            if (!px[i][15]) begin
                if (lkey[i] < k1) begin
                    k2    = k1;
                    id2   = id1;
                    c2    = c1;
                    k1    = lkey[i];
                    id1   = t_layer'(i);
                    c1    = px[i][14:0];
                    semi1 = lsemi[i];
                end else if (lkey[i] < k2) begin
                    k2  = lkey[i];
                    id2 = t_layer'(i);
                    c2  = px[i][14:0];
                end
            end
        end
    end

    // Classify the effect for the back end
    assign top_first = i_cfg.first_mask[id1];
    assign second_ok = i_cfg.second_mask[id2];

    always_comb begin
        o_item.top_color    = c1;
        o_item.second_color = c2;
        o_item.op           = OP_PASS;
        if (!(semi1 && id1 == LAYER_SPRITE)) begin
            unique case (i_cfg.blend_mode)
                MODE_ALPHA:  if (top_first && second_ok) o_item.op = OP_ALPHA;
                MODE_BRIGHT: if (top_first) o_item.op = OP_BRIGHT;
                MODE_DARK:   if (top_first) o_item.op = OP_DARK;
                default:     o_item.op = OP_PASS;
            endcase
        end
    end

endmodule

// File: rtl/lpbc_queue.sv
module lpbc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpbc_pkg::t_item i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lpbc_pkg::t_item o_head
);
    import lpbc_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_AW-1:0] n_wptr, n_rptr;
    logic [QUEUE_CW-1:0] n_count;

    localparam logic [QUEUE_AW-1:0] LAST = QUEUE_AW'(QUEUE_DEPTH - 1);

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        if (i_pop)  n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

endmodule

// File: rtl/lpbc_back.sv
module lpbc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpbc_pkg::t_cfg  i_cfg,
    input  lpbc_pkg::t_item i_item,
    input  logic            i_queue_empty,
    output logic            o_pop,
    lpbc_out_if.source      o_out
);
    import lpbc_pkg::*;

    t_weight eva, evb, ey;
    t_chan   ca  [NUM_CHAN];
    t_chan   cb  [NUM_CHAN];
    t_chan   res [NUM_CHAN];
    logic [9:0] wsum [NUM_CHAN];
    logic [9:0] fprod[NUM_CHAN];
    logic [9:0] dprod[NUM_CHAN];

    logic        r_valid;
    t_color      r_color;
    logic [31:0] r_rgba;
    t_color      n_color;
    logic [31:0] n_rgba;

    assign eva = sat16(i_cfg.alpha_first);
    assign evb = sat16(i_cfg.alpha_second);
    assign ey  = sat16(i_cfg.fade_amount);

    // Per channel arithmetic for the selected effect
    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            ca[k]    = i_item.top_color[CHAN_W*k +: CHAN_W];
            cb[k]    = i_item.second_color[CHAN_W*k +: CHAN_W];
            wsum[k]  = 10'(ca[k]) * 10'(eva) + 10'(cb[k]) * 10'(evb);
            fprod[k] = 10'(CHAN_MAX - ca[k]) * 10'(ey);
            dprod[k] = 10'(ca[k]) * 10'(WEIGHT_MAX - ey);
            case (i_item.op)
                OP_ALPHA:  res[k] = (wsum[k][9:4] > 6'(CHAN_MAX)) ? CHAN_MAX
                                                                  : wsum[k][8:4];
                OP_BRIGHT: res[k] = ca[k] + fprod[k][8:4];
                OP_DARK:   res[k] = dprod[k][8:4];
                default:   res[k] = ca[k];
            endcase
        end
        n_color = {res[2], res[1], res[0]};
        n_rgba  = {ALPHA_OPAQUE, expand5(res[2]), expand5(res[1]), expand5(res[0])};
    end

    // Output register: take from the queue when empty or being drained
    assign o_pop = !i_queue_empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_color <= n_color;
            r_rgba  <= n_rgba;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.final_color = r_color;
    assign o_out.rgba_pixel  = r_rgba;

endmodule

// File: rtl/lpbc_checker.sv
module lpbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [14:0] i_final_color,
    input logic [31:0] i_rgba_pixel
);

    // Output register clears on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_final_color)
                                        && $stable(i_rgba_pixel))
        else $error("stalled result changed");

    // RGBA expansion agrees with the 15-bit colour
    a_rgba_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_rgba_pixel[31:24] == 8'hFF
                     && i_rgba_pixel[23:19] == i_final_color[14:10]
                     && i_rgba_pixel[15:11] == i_final_color[9:5]
                     && i_rgba_pixel[7:3]   == i_final_color[4:0])
        else $error("rgba expansion mismatch");

    // Accepted transaction passes through the queue to the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##2 i_out_valid)
        else $error("accepted pixel did not reach output");

endmodule

bind layer_priority_blend_compositor lpbc_checker u_lpbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_final_color (o_out.final_color),
    .i_rgba_pixel  (o_out.rgba_pixel)
);
